[src/salc_pkg.sv]
`default_nettype none
package salc_pkg;

   localparam int CNT_W  = 32;
   localparam int RANK_W = 3;

   localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
   localparam logic [RANK_W-1:0] RANK_MAX = '1;

   typedef enum logic [1:0] {
      ACT_INSTR  = 2'd0,
      ACT_LOAD   = 2'd1,
      ACT_STORE  = 2'd2,
      ACT_MODIFY = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      CSR_SET_BITS   = 2'd0,
      CSR_WAYS       = 2'd1,
      CSR_BLOCK_BITS = 2'd2
   } csr_index_type;

   typedef enum logic {
      ST_IDLE,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [63:0] addr;
   } req_type;

   typedef struct packed {
      logic             hit;
      logic             miss;
      logic             evicted;
      logic             modify_hit;
      logic [CNT_W-1:0] hits_total;
      logic [CNT_W-1:0] misses_total;
      logic [CNT_W-1:0] evictions_total;
   } rsp_type;

   typedef struct packed {
      logic hit;
      logic miss;
      logic evicted;
   } outcome_type;

   function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] cnt,
                                                 input logic [1:0] inc);
      logic [CNT_W:0] sum;
      sum = {1'b0, cnt} + {{(CNT_W-1){1'b0}}, inc};
      return sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
   endfunction

endpackage
`default_nettype wire

[src/salc_ram.sv]
`default_nettype none
module salc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[src/salc_way_logic.sv]
`default_nettype none
module salc_way_logic #(
   parameter int NUM_WAYS = 8,
   parameter int TAG_W    = 63
) (
   input  wire logic [NUM_WAYS*(TAG_W+salc_pkg::RANK_W)-1:0] row_rd,
   input  wire logic [NUM_WAYS-1:0]                          valid_rd,
   input  wire logic [NUM_WAYS-1:0]                          active,
   input  wire logic [TAG_W-1:0]                             tag,
   output logic      [NUM_WAYS*(TAG_W+salc_pkg::RANK_W)-1:0] row_wr,
   output logic      [NUM_WAYS-1:0]                          valid_wr,
   output salc_pkg::outcome_type                             outcome
);

   localparam int RANK_W  = salc_pkg::RANK_W;
   localparam int ENTRY_W = TAG_W + RANK_W;

   logic [NUM_WAYS-1:0] hit_sel;
   logic [NUM_WAYS-1:0] free_sel;
   logic [NUM_WAYS-1:0] best_sel;
   logic                hit_any;
   logic                free_any;
   logic [NUM_WAYS-1:0] sel;
   logic [RANK_W:0]     old_rank;

   always_comb begin : search
      logic [RANK_W-1:0] best_rank;
      logic [RANK_W-1:0] rank_w;
      hit_sel   = '0;
      free_sel  = '0;
      best_sel  = '0;
      hit_any   = 1'b0;
      free_any  = 1'b0;
      best_rank = '0;
      for (int w = 0; w < NUM_WAYS; w++) begin
         rank_w = row_rd[w*ENTRY_W +: RANK_W];
         if (!hit_any && active[w] && valid_rd[w] &&
             row_rd[w*ENTRY_W+RANK_W +: TAG_W] == tag) begin
            hit_any    = 1'b1;
            hit_sel[w] = 1'b1;
         end
         if (!free_any && active[w] && !valid_rd[w]) begin
            free_any    = 1'b1;
            free_sel[w] = 1'b1;
         end
         if (active[w] && (w == 0 || rank_w > best_rank)) begin
            best_rank   = rank_w;
            best_sel    = '0;
            best_sel[w] = 1'b1;
         end
      end
   end

   always_comb begin : update
      logic [RANK_W-1:0] hit_rank;
      logic [RANK_W-1:0] rank_w;
      hit_rank = '0;
      for (int w = 0; w < NUM_WAYS; w++) begin
         hit_rank = hit_rank | (row_rd[w*ENTRY_W +: RANK_W] & {RANK_W{hit_sel[w]}});
      end
      old_rank = hit_any ? {1'b0, hit_rank} : {1'b1, {RANK_W{1'b0}}};
      sel      = hit_any ? hit_sel : (free_any ? free_sel : best_sel);
      row_wr   = row_rd;
      for (int w = 0; w < NUM_WAYS; w++) begin
         rank_w = row_rd[w*ENTRY_W +: RANK_W];
         if (active[w] && sel[w]) begin
            row_wr[w*ENTRY_W +: ENTRY_W] = {tag, {RANK_W{1'b0}}};
         end else if (active[w] && valid_rd[w] && {1'b0, rank_w} < old_rank &&
                      rank_w < salc_pkg::RANK_MAX) begin
            row_wr[w*ENTRY_W +: RANK_W] = rank_w + RANK_W'(1);
         end
      end
      valid_wr = valid_rd | (sel & active);
   end

   assign outcome.hit     = hit_any;
   assign outcome.miss    = !hit_any;
   assign outcome.evicted = !hit_any && !free_any;

endmodule
`default_nettype wire

[src/set_assoc_lru_cache_sim_core.sv]
// An accepted item's set row is read from the tag/rank memory; in the UPDATE state the row
// is written back for accesses and the result loaded into the output register. A new item
// is taken only in IDLE, after the write-back; a stalled result holds the write-back stage.
// Reset: synchronous, active high; clears valid bits, totals, control and
// restores set_bits, ways and block_bits to 1. No clearing pass is needed.
`default_nettype none
module set_assoc_lru_cache_sim_core #(
   parameter int NUM_SETS  = 32,
   parameter int NUM_WAYS  = 8,
   parameter int ADDR_BITS = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire salc_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output salc_pkg::rsp_type      rsp_data,
   input  wire logic              csr_we,
   input  wire logic [1:0]        csr_index,
   input  wire logic [5:0]        csr_wdata
);

   localparam int SET_W   = $clog2(NUM_SETS);
   localparam int MAX_SB  = $clog2(NUM_SETS + 1) - 1;
   localparam int TAG_W   = ADDR_BITS - 1;
   localparam int ENTRY_W = TAG_W + salc_pkg::RANK_W;
   localparam int ROW_W   = NUM_WAYS * ENTRY_W;
   localparam int CNT_W   = salc_pkg::CNT_W;

   logic [2:0] set_bits_ff;
   logic [3:0] ways_ff;
   logic [5:0] block_bits_ff;

   salc_pkg::state_type state_ff, state_in;
   logic                accept;
   logic                advance;
   logic                update_go;

   logic [2:0]           sb_eff;
   logic [3:0]           nw_eff;
   logic [ADDR_BITS-1:0] addr_m;
   logic [ADDR_BITS-1:0] offset_sh;
   logic [6:0]           tag_sh;
   logic [SET_W-1:0]     set_idx;
   logic [TAG_W-1:0]     tag_idx;
   logic [NUM_WAYS-1:0]  active;

   logic [1:0]          action_ff;
   logic [SET_W-1:0]    set_ff;
   logic [TAG_W-1:0]    tag_ff;
   logic [NUM_WAYS-1:0] active_ff;

   logic [NUM_WAYS-1:0] valid_ff [NUM_SETS];
   logic [ROW_W-1:0]    row_rd;
   logic [ROW_W-1:0]    row_wr;
   logic [NUM_WAYS-1:0] valid_wr;
   logic                ram_we;

   salc_pkg::outcome_type outcome;
   logic                  is_access;
   logic                  is_modify;
   logic                  hit_q;
   logic                  miss_q;
   logic                  evict_q;

   logic [CNT_W-1:0] hits_ff, hits_in;
   logic [CNT_W-1:0] misses_ff, misses_in;
   logic [CNT_W-1:0] evicts_ff, evicts_in;

   logic              rsp_valid_ff, rsp_valid_in;
   salc_pkg::rsp_type rsp_data_ff, rsp_data_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff   <= 3'd1;
         ways_ff       <= 4'd1;
         block_bits_ff <= 6'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            salc_pkg::CSR_SET_BITS:   set_bits_ff   <= csr_wdata[2:0];
            salc_pkg::CSR_WAYS:       ways_ff       <= csr_wdata[3:0];
            salc_pkg::CSR_BLOCK_BITS: block_bits_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (set_bits_ff == 3'd0) begin
         sb_eff = 3'd1;
      end else if (32'(set_bits_ff) > MAX_SB) begin
         sb_eff = 3'(MAX_SB);
      end else begin
         sb_eff = set_bits_ff;
      end
      if (ways_ff == 4'd0) begin
         nw_eff = 4'd1;
      end else if (32'(ways_ff) > NUM_WAYS) begin
         nw_eff = 4'(NUM_WAYS);
      end else begin
         nw_eff = ways_ff;
      end
      for (int w = 0; w < NUM_WAYS; w++) begin
         active[w] = (w < 32'(nw_eff));
      end
   end

   assign addr_m    = req_data.addr[ADDR_BITS-1:0];
   assign offset_sh = addr_m >> block_bits_ff;
   assign tag_sh    = {4'd0, sb_eff} + {1'b0, block_bits_ff};
   assign set_idx   = SET_W'(offset_sh) & SET_W'((6'd1 << sb_eff) - 6'd1);
   assign tag_idx   = TAG_W'(addr_m >> tag_sh);

   always_comb begin
      unique case (state_ff)
         salc_pkg::ST_IDLE:   state_in = accept ? salc_pkg::ST_UPDATE : salc_pkg::ST_IDLE;
         salc_pkg::ST_UPDATE: state_in = advance ? salc_pkg::ST_IDLE : salc_pkg::ST_UPDATE;
         default:             state_in = salc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      advance = !rsp_valid_ff || rsp_ready;
      unique case (state_ff)
         salc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            update_go = 1'b0;
         end
         salc_pkg::ST_UPDATE: begin
            req_ready = 1'b0;
            update_go = advance;
         end
         default: begin
            req_ready = 1'b0;
            update_go = 1'b0;
         end
      endcase
      accept = req_valid && req_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= salc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= req_data.action;
         set_ff    <= set_idx;
         tag_ff    <= tag_idx;
         active_ff <= active;
      end
   end

   salc_ram #(
      .WIDTH (ROW_W),
      .DEPTH (NUM_SETS)
   ) u_row_ram (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (set_idx),
      .rd_data (row_rd),
      .wr_en   (ram_we),
      .wr_addr (set_ff),
      .wr_data (row_wr)
   );

   salc_way_logic #(
      .NUM_WAYS (NUM_WAYS),
      .TAG_W    (TAG_W)
   ) u_way_logic (
      .row_rd   (row_rd),
      .valid_rd (valid_ff[set_ff]),
      .active   (active_ff),
      .tag      (tag_ff),
      .row_wr   (row_wr),
      .valid_wr (valid_wr),
      .outcome  (outcome)
   );

   assign is_access = (action_ff != salc_pkg::ACT_INSTR);
   assign is_modify = (action_ff == salc_pkg::ACT_MODIFY);
   assign ram_we    = update_go && is_access;
   assign hit_q     = is_access && outcome.hit;
   assign miss_q    = is_access && outcome.miss;
   assign evict_q   = is_access && outcome.evicted;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NUM_SETS; s++) begin
            valid_ff[s] <= '0;
         end
      end else if (ram_we) begin
         valid_ff[set_ff] <= valid_wr;
      end
   end

   assign hits_in   = salc_pkg::sat_add(hits_ff, {1'b0, hit_q} + {1'b0, is_modify});
   assign misses_in = salc_pkg::sat_add(misses_ff, {1'b0, miss_q});
   assign evicts_in = salc_pkg::sat_add(evicts_ff, {1'b0, evict_q});

   always_ff @(posedge clock) begin
      if (reset) begin
         hits_ff   <= '0;
         misses_ff <= '0;
         evicts_ff <= '0;
      end else if (update_go) begin
         hits_ff   <= hits_in;
         misses_ff <= misses_in;
         evicts_ff <= evicts_in;
      end
   end

   always_comb begin
      rsp_data_in.hit             = hit_q;
      rsp_data_in.miss            = miss_q;
      rsp_data_in.evicted         = evict_q;
      rsp_data_in.modify_hit      = is_modify;
      rsp_data_in.hits_total      = hits_in;
      rsp_data_in.misses_total    = misses_in;
      rsp_data_in.evictions_total = evicts_in;
      if (update_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (update_go) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == salc_pkg::ST_UPDATE)
      else $error("accepted item did not enter update");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == salc_pkg::ST_UPDATE))
      else $error("result appeared without an update");

   assert property (@(posedge clock) disable iff (reset)
      update_go && is_access |-> $onehot({outcome.hit, outcome.miss}) &&
                                 (!outcome.evicted || outcome.miss))
      else $error("inconsistent lookup outcome");

   assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> hits_ff >= $past(hits_ff) && misses_ff >= $past(misses_ff) &&
               evicts_ff >= $past(evicts_ff))
      else $error("running total decreased");

endmodule
`default_nettype wire

[verif/set_assoc_lru_cache_sim_core_test.sv]
`timescale 1ns / 1ps
module set_assoc_lru_cache_sim_core_test;
   import salc_pkg::*;

   localparam int NUM_SETS       = 32;
   localparam int NUM_WAYS       = 8;
   localparam int ADDR_BITS      = 64;
   localparam int MAX_SET_BITS   = $clog2(NUM_SETS);
   localparam int LINES          = NUM_SETS * NUM_WAYS;
   localparam int PHASE_ITEMS    = 150;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD      = 150;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rsp_type    rsp_data;
   logic       csr_we = 1'b0;
   logic [1:0] csr_index = '0;
   logic [5:0] csr_wdata = '0;

   set_assoc_lru_cache_sim_core #(
      .NUM_SETS(NUM_SETS),
      .NUM_WAYS(NUM_WAYS),
      .ADDR_BITS(ADDR_BITS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // cache image
   logic                line_live [LINES];
   logic [63:0]         line_tagv [LINES];
   logic [RANK_W-1:0]   line_age  [LINES];
   logic [CNT_W-1:0]    hit_tot;
   logic [CNT_W-1:0]    miss_tot;
   logic [CNT_W-1:0]    evict_tot;
   logic [2:0]          cfg_set_bits;
   logic [3:0]          cfg_ways;
   logic [5:0]          cfg_block_bits;

   req_type     pend_q [$];
   rsp_type     outcome_q [$];
   logic [63:0] addr_pool [$];
   rsp_type     oldest;

   int  n_queued = 0;
   int  n_acc = 0;
   int  n_rsp = 0;
   int  err_cnt = 0;
   int  stall_cycles = 0;
   int  idle_pct = 0;
   int  send_idle = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;
   bit  req_fire = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int eff_set_bits();
      int sb;
      sb = cfg_set_bits;
      if (sb < 1) sb = 1;
      if (sb > MAX_SET_BITS) sb = MAX_SET_BITS;
      return sb;
   endfunction

   function automatic int eff_ways();
      int nw;
      nw = cfg_ways;
      if (nw < 1) nw = 1;
      if (nw > NUM_WAYS) nw = NUM_WAYS;
      return nw;
   endfunction

   function automatic logic [CNT_W-1:0] sat_bump(input logic [CNT_W-1:0] c);
      return (c == CNT_MAX) ? c : c + 1'b1;
   endfunction

   function automatic rsp_type lookup_cache(input req_type r);
      rsp_type     res;
      int          sb, nw, bb, base, way, w, idx, best, set_idx;
      logic [63:0] tag;
      logic        found, have_free;
      logic [3:0]  old;
      logic [RANK_W-1:0] best_rank;
      res = '0;
      if (r.action != ACT_INSTR) begin
         sb = eff_set_bits();
         nw = eff_ways();
         bb = cfg_block_bits;
         set_idx = int'((r.addr >> bb) & ((64'd1 << sb) - 64'd1));
         tag = r.addr >> (sb + bb);
         base = set_idx * NUM_WAYS;
         found = 1'b0;
         way = 0;
         old = 4'd8;
         for (w = 0; w < nw; w++) begin
            if (!found && line_live[base + w] && line_tagv[base + w] == tag) begin
               found = 1'b1;
               way = w;
            end
         end
         if (found) begin
            res.hit = 1'b1;
            old = {1'b0, line_age[base + way]};
            hit_tot = sat_bump(hit_tot);
         end else begin
            have_free = 1'b0;
            best = 0;
            best_rank = '0;
            for (w = 0; w < nw; w++) begin
               if (!have_free) begin
                  if (!line_live[base + w]) begin
                     have_free = 1'b1;
                     way = w;
                  end else if (w == 0 || line_age[base + w] > best_rank) begin
                     best_rank = line_age[base + w];
                     best = w;
                  end
               end
            end
            if (!have_free) begin
               way = best;
               res.evicted = 1'b1;
               evict_tot = sat_bump(evict_tot);
            end
            res.miss = 1'b1;
            miss_tot = sat_bump(miss_tot);
         end
         for (w = 0; w < nw; w++) begin
            idx = base + w;
            if (w != way && line_live[idx] && {1'b0, line_age[idx]} < old &&
                line_age[idx] < RANK_MAX)
               line_age[idx] = line_age[idx] + 1'b1;
         end
         line_live[base + way] = 1'b1;
         line_tagv[base + way] = tag;
         line_age[base + way] = '0;
         if (r.action == ACT_MODIFY) begin
            res.modify_hit = 1'b1;
            hit_tot = sat_bump(hit_tot);
         end
      end
      res.hits_total = hit_tot;
      res.misses_total = miss_tot;
      res.evictions_total = evict_tot;
      return res;
   endfunction

   task automatic check_field(input string name, input logic [CNT_W-1:0] got,
                              input logic [CNT_W-1:0] want);
      if (got !== want) begin
         $display("%0t mismatch %s expected %0h actual %0h", $time, name, want, got);
         err_cnt++;
      end
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !req_fire)) begin
         if (send_idle > 0) begin
            send_idle--;
            req_valid <= 1'b0;
         end else if (pend_q.size() > 0) begin
            if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
               send_idle = $urandom_range(0, 9);
               req_valid <= 1'b0;
            end else begin
               req_data <= pend_q.pop_front();
               req_valid <= 1'b1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!hold_done && n_rsp >= 400) begin
         hold_done = 1'b1;
         hold_left = LONG_HOLD - 1;
         rsp_ready <= 1'b0;
      end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         hold_left = $urandom_range(0, 9);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         req_fire <= 1'b0;
         stall_cycles = 0;
      end else begin
         req_fire <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            n_rsp++;
            if (outcome_q.size() == 0) begin
               $display("%0t unexpected result expected none actual %0h", $time, rsp_data);
               err_cnt++;
            end else begin
               oldest = outcome_q.pop_front();
               check_field("hit", rsp_data.hit, oldest.hit);
               check_field("miss", rsp_data.miss, oldest.miss);
               check_field("evicted", rsp_data.evicted, oldest.evicted);
               check_field("modify_hit", rsp_data.modify_hit, oldest.modify_hit);
               check_field("hits_total", rsp_data.hits_total, oldest.hits_total);
               check_field("misses_total", rsp_data.misses_total, oldest.misses_total);
               check_field("evictions_total", rsp_data.evictions_total,
                           oldest.evictions_total);
            end
         end
         if (req_valid && req_ready) begin
            outcome_q.push_back(lookup_cache(req_data));
            n_acc++;
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
   end

   initial begin
      while (stall_cycles < WATCHDOG_LIMIT) @(negedge clock);
      $display("Verification failed");
      $finish;
   end

   task automatic push_item(input action_type act, input logic [63:0] addr);
      req_type r;
      r.action = act;
      r.addr = addr;
      pend_q.push_back(r);
      n_queued++;
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [5:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_SET_BITS:   cfg_set_bits = val[2:0];
         CSR_WAYS:       cfg_ways = val[3:0];
         CSR_BLOCK_BITS: cfg_block_bits = val;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain();
      while (n_acc != n_queued || outcome_q.size() != 0) @(negedge clock);
   endtask

   task automatic fill_accesses(input int count);
      logic [63:0] t, off_mask, addr;
      int          sb, nw, bb, nsets, ntags, s, k, j;
      sb = eff_set_bits();
      nw = eff_ways();
      bb = cfg_block_bits;
      off_mask = (64'd1 << bb) - 64'd1;
      nsets = ((1 << sb) < 4) ? (1 << sb) : $urandom_range(1, 4);
      addr_pool.delete();
      for (k = 0; k < nsets; k++) begin
         s = $urandom_range(0, (1 << sb) - 1);
         ntags = nw + $urandom_range(0, 2);
         for (j = 0; j < ntags; j++) begin
            t = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
                                            : 64'($urandom_range(0, 63));
            addr_pool.push_back((t << (sb + bb)) | (64'(s) << bb));
         end
      end
      for (k = 0; k < count; k++) begin
         if ($urandom_range(0, 9) == 0)
            addr = {$urandom, $urandom};
         else
            addr = addr_pool[$urandom_range(0, addr_pool.size() - 1)] |
                   ({$urandom, $urandom} & off_mask);
         push_item(action_type'($urandom_range(0, 3)), addr);
      end
   endtask

   task automatic run_phase(input logic [5:0] sbv, input logic [5:0] wv,
                            input logic [5:0] bbv, input int pct);
      write_reg(CSR_SET_BITS, sbv);
      write_reg(CSR_WAYS, wv);
      write_reg(CSR_BLOCK_BITS, bbv);
      idle_pct = pct;
      @(posedge clock);
      fill_accesses(PHASE_ITEMS);
      drain();
   endtask

   function automatic int pick_pct();
      case ($urandom_range(0, 2))
         0: return 0;
         1: return 15;
         default: return 35;
      endcase
   endfunction

   initial begin
      int i;
      for (i = 0; i < LINES; i++) begin
         line_live[i] = 1'b0;
         line_tagv[i] = '0;
         line_age[i] = '0;
      end
      hit_tot = '0;
      miss_tot = '0;
      evict_tot = '0;
      cfg_set_bits = 3'd1;
      cfg_ways = 4'd1;
      cfg_block_bits = 6'd1;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      idle_pct = 25;
      @(posedge clock);
      push_item(ACT_INSTR, 64'h0);
      push_item(ACT_LOAD, 64'h0);
      push_item(ACT_LOAD, 64'h1);
      push_item(ACT_STORE, '1);
      push_item(ACT_MODIFY, '1);
      push_item(ACT_MODIFY, 64'h4);
      push_item(ACT_LOAD, 64'h0);
      push_item(ACT_STORE, 64'h8000_0000_0000_0000);
      push_item(ACT_INSTR, '1);
      push_item(ACT_LOAD, 64'h8000_0000_0000_0001);
      push_item(ACT_STORE, 64'h2);
      push_item(ACT_MODIFY, 64'h7FFF_FFFF_FFFF_FFFF);
      push_item(ACT_LOAD, 64'h5555_5555_5555_5555);
      push_item(ACT_STORE, 64'hAAAA_AAAA_AAAA_AAAA);
      drain();

      run_phase(6'd5, 6'd8, 6'd1, 20);
      run_phase(6'd1, 6'd1, 6'd58, 30);
      run_phase(6'd0, 6'd0, 6'd4, 10);
      run_phase(6'd7, 6'd15, 6'd63, 25);
      run_phase(6'd6, 6'd9, 6'd12, 15);
      for (i = 0; i < 6; i++) begin
         run_phase(6'($urandom_range(0, 7)), 6'($urandom_range(0, 15)),
                   ($urandom_range(0, 4) == 0) ? 6'($urandom_range(1, 63))
                                               : 6'($urandom_range(1, 20)),
                   pick_pct());
      end
      run_phase(6'($urandom_range(1, 5)), 6'($urandom_range(1, 8)),
                6'($urandom_range(1, 16)), 0);

      repeat (8) @(negedge clock);
      if (err_cnt == 0 && outcome_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
